/* sv/bdve_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdve_pkg: shared types and constants of the button digit value editor
// Holds value widths, register indexes, button and status codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bdve_pkg;

	// Width of the edited value and of a value times a digit or radix.
	localparam int VALUE_BITS = 32;
	localparam int PROD_W     = VALUE_BITS + 5;
	localparam logic [VALUE_BITS-1:0] VMASK = {VALUE_BITS{1'b1}};

	// Idle counter saturation point.
	localparam logic [15:0] IDLE_SAT = 16'hFFFF;

	// Register reset values.
	localparam logic [4:0]  RST_RADIX       = 5'd10;
	localparam logic [4:0]  RST_DIGIT_COUNT = 5'd10;
	localparam logic [31:0] RST_VALUE_MIN   = 32'd0;
	localparam logic [31:0] RST_VALUE_MAX   = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_INIT_VALUE  = 32'd0;
	localparam logic [15:0] RST_TIMEOUT     = 16'd5000;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_RADIX       = 3'd0,
		CFG_DIGIT_COUNT = 3'd1,
		CFG_VALUE_MIN   = 3'd2,
		CFG_VALUE_MAX   = 3'd3,
		CFG_INIT_VALUE  = 3'd4,
		CFG_TIMEOUT     = 3'd5
	} cfg_idx_t;

	// Button codes.
	localparam logic [2:0] KEY_NONE   = 3'd0;
	localparam logic [2:0] KEY_SELECT = 3'd1;
	localparam logic [2:0] KEY_LEFT   = 3'd2;
	localparam logic [2:0] KEY_RIGHT  = 3'd3;
	localparam logic [2:0] KEY_UP     = 3'd4;
	localparam logic [2:0] KEY_DOWN   = 3'd5;

	// Status codes.
	localparam logic [1:0] STAT_EDIT    = 2'd0;
	localparam logic [1:0] STAT_SELECT  = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take the input beat
		logic pow_step;    // weight <= weight * radix
		logic div_start;   // launch the divider
		logic div_second;  // second division: remainder by weight
		logic rem_take;    // keep the remainder of the first division
		logic digit_take;  // form the stepped digit and the rest
		logic mul_load;    // new digit times weight
		logic add_take;    // rest plus product, saturated
		logic clamp_take;  // clamp and write the edited value
		logic publish;     // load the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic step_req;    // the input beat asks for a digit step
		logic pow_done;    // digit weight is complete
		logic pow_ovf;     // digit weight does not fit the value width
		logic div_done;    // divider result is ready
	} sts_t;

endpackage

/* sv/bdve_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdve_div: restoring divider, one quotient bit per cycle
// Divides a value-wide dividend by a wider divisor; done pulses for one
// cycle when quotient and remainder are ready and they hold until restart.
// ----------------------------------------------------------------------------
module bdve_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bdve_pkg::VALUE_BITS-1:0] dividend,
	input  logic [bdve_pkg::PROD_W-1:0]     divisor,
	output logic                          done,
	output logic [bdve_pkg::VALUE_BITS-1:0] quot,
	output logic [bdve_pkg::PROD_W-1:0]     rem
);
	import bdve_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PROD_W-1:0]     div_q;
	logic [PROD_W-1:0]     rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [PROD_W:0]       trial;
	logic [PROD_W:0]       diff;
	logic                  ge;
	logic [PROD_W-1:0]     rem_d;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
		rem_d = ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
	end

	// Sequencing of the division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + CNT_W'(1);
			busy_q <= (cnt_q != LAST_STEP);
			done_q <= (cnt_q == LAST_STEP);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* sv/bdve_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdve_dp: datapath of the button digit value editor
// Holds the registers, the session state, the digit step arithmetic
// (weight, divider, multiplier, clamp) and the output register.
// ----------------------------------------------------------------------------
module bdve_dp #(
	parameter int MAX_DIGITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic [2:0]                    button,
	input  logic                          restart,
	input  bdve_pkg::cmd_t                cmd,
	output bdve_pkg::sts_t                sts,
	output logic [bdve_pkg::VALUE_BITS-1:0] current_value,
	output logic [3:0]                    cursor_digit,
	output logic [1:0]                    status
);
	import bdve_pkg::*;

	localparam int LEN_W = $clog2(MAX_DIGITS + 1);
	localparam int RST_LEN = (MAX_DIGITS < 10) ? MAX_DIGITS : 10;
	localparam logic [3:0] RST_CURSOR = 4'(RST_LEN - 1);

	// Configuration registers.
	logic [4:0]  radix_q;
	logic [4:0]  digit_count_q;
	logic [31:0] value_min_q;
	logic [31:0] value_max_q;
	logic [31:0] init_value_q;
	logic [15:0] timeout_q;

	// Session state.
	logic [VALUE_BITS-1:0] edit_q;
	logic [3:0]            cursor_q;
	logic [2:0]            last_q;
	logic [15:0]           idle_q;
	logic [1:0]            status_q;

	// Digit step working registers.
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] weight_q;
	logic [LEN_W-1:0]      cnt_q;
	logic [LEN_W-1:0]      idx_q;
	logic [4:0]            base_q;
	logic                  up_q;
	logic [VALUE_BITS-1:0] r_q;
	logic [VALUE_BITS-1:0] rest_q;
	logic [4:0]            nd_q;
	logic [PROD_W-1:0]     prod_q;

	// Output register.
	logic [VALUE_BITS-1:0] out_value_q;
	logic [3:0]            out_cursor_q;
	logic [1:0]            out_status_q;

	logic [5:0]            dc6;
	logic [5:0]            len6;
	logic [5:0]            lenm1;
	logic [5:0]            cursor6;
	logic [5:0]            idx6;
	logic [4:0]            eff_radix;
	logic [15:0]           idle_inc;
	logic                  timed_out;
	logic                  changed;
	logic                  step_req;
	logic                  pow_done;
	logic                  pow_ovf;
	logic [3:0]            cursor_nx;
	logic [4:0]            mul_b;
	logic [PROD_W-1:0]     prod;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [PROD_W-1:0]     div_divisor;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [PROD_W-1:0]     div_rem;
	logic [4:0]            digit;
	logic [4:0]            nd;
	logic [PROD_W:0]       sum;
	logic [VALUE_BITS-1:0] clamped;

	// Effective digit count, radix and cursor arithmetic.
	always_comb begin
		dc6 = {1'b0, digit_count_q};
		if (dc6 == 6'd0) begin
			len6 = 6'd1;
		end else if (dc6 > 6'(MAX_DIGITS)) begin
			len6 = 6'(MAX_DIGITS);
		end else begin
			len6 = dc6;
		end
		lenm1   = len6 - 6'd1;
		cursor6 = {2'b00, cursor_q};
		idx6    = (cursor6 < len6) ? (lenm1 - cursor6) : 6'd0;
		if (radix_q < 5'd2) begin
			eff_radix = 5'd2;
		end else if (radix_q > 5'd16) begin
			eff_radix = 5'd16;
		end else begin
			eff_radix = radix_q;
		end
	end

	// Tick decision for the input beat.
	always_comb begin
		idle_inc  = (idle_q == IDLE_SAT) ? idle_q : idle_q + 16'd1;
		timed_out = (idle_inc > timeout_q);
		changed   = (button != last_q);
		step_req  = !restart && !timed_out && changed &&
			((button == KEY_UP) || (button == KEY_DOWN));
		cursor_nx = cursor_q;
		case (button)
			KEY_LEFT: begin
				cursor_nx = (cursor6 == 6'd0) ? lenm1[3:0] : cursor_q - 4'd1;
			end
			KEY_RIGHT: begin
				cursor_nx = (cursor6 >= lenm1) ? 4'd0 : cursor_q + 4'd1;
			end
			default: begin
				cursor_nx = cursor_q;
			end
		endcase
	end

	// Shared multiplier: weight times radix, or weight times the new digit.
	always_comb begin
		mul_b    = cmd.mul_load ? nd_q : base_q;
		prod     = PROD_W'(weight_q) * PROD_W'(mul_b);
		pow_done = (cnt_q == idx_q);
		pow_ovf  = (cnt_q != idx_q) && (prod[PROD_W-1:VALUE_BITS] != '0);
	end

	// Divider operands: value by weight times radix, then that remainder by weight.
	always_comb begin
		div_dividend = cmd.div_second ? div_rem[VALUE_BITS-1:0] : v_q;
		div_divisor  = cmd.div_second ? PROD_W'(weight_q) : prod;
	end

	bdve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Status bundle, in the member order of sts_t.
	assign sts = {step_req, pow_done, pow_ovf, div_done};

	// New digit with wraparound; the quotient of the second division is below the radix.
	always_comb begin
		digit = {1'b0, div_quot[3:0]};
		if (up_q) begin
			nd = (digit == base_q - 5'd1) ? 5'd0 : digit + 5'd1;
		end else begin
			nd = (digit == 5'd0) ? base_q - 5'd1 : digit - 5'd1;
		end
	end

	// Saturating add and the final clamp.
	always_comb begin
		sum = {1'b0, prod_q} + (PROD_W + 1)'(rest_q);
		if (v_q < value_min_q[VALUE_BITS-1:0]) begin
			clamped = value_min_q[VALUE_BITS-1:0];
		end else if (v_q > value_max_q[VALUE_BITS-1:0]) begin
			clamped = value_max_q[VALUE_BITS-1:0];
		end else begin
			clamped = v_q;
		end
	end

	// Configuration registers and session state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RST_RADIX;
			digit_count_q <= RST_DIGIT_COUNT;
			value_min_q   <= RST_VALUE_MIN;
			value_max_q   <= RST_VALUE_MAX;
			init_value_q  <= RST_INIT_VALUE;
			timeout_q     <= RST_TIMEOUT;
			edit_q        <= RST_INIT_VALUE[VALUE_BITS-1:0];
			cursor_q      <= RST_CURSOR;
			last_q        <= KEY_NONE;
			idle_q        <= '0;
			status_q      <= STAT_EDIT;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RADIX:       radix_q       <= cfg_data[4:0];
					CFG_DIGIT_COUNT: digit_count_q <= cfg_data[4:0];
					CFG_VALUE_MIN:   value_min_q   <= cfg_data;
					CFG_VALUE_MAX:   value_max_q   <= cfg_data;
					CFG_INIT_VALUE:  init_value_q  <= cfg_data;
					CFG_TIMEOUT:     timeout_q     <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				if (restart) begin
					edit_q   <= init_value_q[VALUE_BITS-1:0];
					cursor_q <= lenm1[3:0];
					last_q   <= button;
					idle_q   <= '0;
					status_q <= STAT_EDIT;
				end else if (timed_out) begin
					idle_q   <= idle_inc;
					status_q <= STAT_TIMEOUT;
				end else if (changed) begin
					last_q   <= button;
					idle_q   <= '0;
					cursor_q <= cursor_nx;
					status_q <= (button == KEY_SELECT) ? STAT_SELECT : STAT_EDIT;
				end else begin
					idle_q   <= idle_inc;
					status_q <= STAT_EDIT;
				end
			end
			if (cmd.clamp_take) begin
				edit_q <= clamped;
			end
		end
	end

	// Digit step working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q      <= edit_q;
			weight_q <= VALUE_BITS'(1);
			cnt_q    <= '0;
			idx_q    <= idx6[LEN_W-1:0];
			base_q   <= eff_radix;
			up_q     <= (button == KEY_UP);
		end
		if (cmd.pow_step) begin
			weight_q <= prod[VALUE_BITS-1:0];
			cnt_q    <= cnt_q + LEN_W'(1);
		end
		if (cmd.rem_take) begin
			r_q <= div_rem[VALUE_BITS-1:0];
		end
		if (cmd.digit_take) begin
			rest_q <= v_q - r_q + div_rem[VALUE_BITS-1:0];
			nd_q   <= nd;
		end
		if (cmd.mul_load) begin
			prod_q <= prod;
		end
		if (cmd.add_take) begin
			v_q <= (sum > (PROD_W + 1)'(VMASK)) ? VMASK : sum[VALUE_BITS-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_value_q  <= edit_q;
			out_cursor_q <= cursor_q;
			out_status_q <= status_q;
		end
	end

	assign current_value = out_value_q;
	assign cursor_digit  = out_cursor_q;
	assign status        = out_status_q;

endmodule

/* sv/bdve_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdve_ctrl: controller of the button digit value editor
// Sequences one tick: accept, digit weight, two divisions, multiply, add,
// clamp and hand-off to the output register; owns the output valid flag.
// ----------------------------------------------------------------------------
module bdve_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output bdve_pkg::cmd_t cmd,
	input  bdve_pkg::sts_t sts
);
	import bdve_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_POW   = 8'b0000_0010,
		ST_DIV1  = 8'b0000_0100,
		ST_DIV2  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_ADD   = 8'b0010_0000,
		ST_CLAMP = 8'b0100_0000,
		ST_PUB   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = sts.step_req ? ST_POW : ST_PUB;
				end
			end
			ST_POW: begin
				if (sts.pow_done) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV1;
				end else if (sts.pow_ovf) begin
					state_d = ST_CLAMP;
				end else begin
					cmd.pow_step = 1'b1;
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.rem_take   = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_second = 1'b1;
					state_d        = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.digit_take = 1'b1;
					state_d        = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_take = 1'b1;
				state_d      = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp_take = 1'b1;
				state_d        = ST_PUB;
			end
			ST_PUB: begin
				if (!out_valid_q || m_axis_tready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	// A tick without a digit step goes straight to the output hand-off.
	a_plain_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !sts.step_req) |=> (state_q == ST_PUB))
		else $error("plain tick did not go to hand-off");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || m_axis_tready))
		else $error("output register overwritten");

	// The first division is left only when the divider reports done.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 && !sts.div_done) |=> (state_q == ST_DIV1))
		else $error("left first division early");

	// A published result is offered in the next cycle.
	a_pub_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> m_axis_tvalid)
		else $error("published result not offered");

endmodule

/* sv/button_digit_value_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_digit_value_editor: button-driven base-N digit value editor
// One input beat per tick; each beat gives one result beat with the value,
// the cursor position and the session status.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     content
//  s_axis    in   s_axis_tvalid/s_axis_tready   button [2:0], restart [3]
//  m_axis    out  m_axis_tvalid/m_axis_tready   value [31:0], cursor [35:32],
//                                               status [37:36]
//  cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// A tick without a digit step runs accept and hand-off only; a digit step runs
// accept, then k weight multiplies and a check, k being the cursor's distance
// from the rightmost digit, two divider passes, then multiply, add, clamp and
// hand-off. A too large digit weight skips straight to clamp.
// Reset loads the register defaults and the session start state at once.
// A stalled output holds the result; the next beat is accepted and waits.
// ----------------------------------------------------------------------------
module button_digit_value_editor #(
	parameter int MAX_DIGITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // button [2:0], restart [3], zero [7:4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // current_value [31:0], cursor_digit [35:32],
	                                    // status [37:36], zero [39:38]
);
	import bdve_pkg::*;

	cmd_t                  cmd;
	sts_t                  sts;
	logic [VALUE_BITS-1:0] current_value;
	logic [3:0]            cursor_digit;
	logic [1:0]            status;

	bdve_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	bdve_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.button        (s_axis_tdata[2:0]),
		.restart       (s_axis_tdata[3]),
		.cmd           (cmd),
		.sts           (sts),
		.current_value (current_value),
		.cursor_digit  (cursor_digit),
		.status        (status)
	);

	// Result beat packing.
	assign m_axis_tdata = {2'b00, status, cursor_digit, current_value};

endmodule

/* tb/tb_button_digit_value_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_digit_value_editor: self-checking bench of the digit value editor
// A directed table opens the run: button wraps, digit steps with overflow,
// unused button codes, restart, out-of-range radix and digit count, a cursor
// past the last digit, an oversized digit weight, an inverted clamp range and
// timeouts. Random editing sessions follow under changing settings and
// handshake pressure.
// Each result beat is checked against its table entry or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_button_digit_value_editor;
	import bdve_pkg::*;

	localparam int          MAX_DIGITS   = 16;
	localparam int          CYCLE_LIMIT  = 2_000_000;
	localparam int          SETTLE_TICKS = 100;
	localparam int          MAX_SHOWN    = 10;
	localparam logic [2:0]  KEY_SPARE_A  = 3'd6;
	localparam logic [2:0]  KEY_SPARE_B  = 3'd7;
	localparam logic [2:0]  CFG_SPARE_A  = 3'd6;
	localparam logic [2:0]  CFG_SPARE_B  = 3'd7;
	localparam logic [63:0] VALUE_ONES   = 64'h0000_0000_FFFF_FFFF;

	// One result beat, laid out as on the master side.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  cursor;
		logic [31:0] value;
	} edit_result_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [2:0]   button;
		logic         restart;
		logic         known;
		edit_result_t want;
		logic [2:0]   reg_idx;
		logic [31:0]  reg_data;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_RADIX;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // button [2:0], restart [3], zero [7:4]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;         // current_value [31:0], cursor_digit [35:32],
	                                   // status [37:36], zero [39:38]

	// Editor settings and session state as the model sees them.
	logic [4:0]  radix_q;
	logic [4:0]  digits_q;
	logic [31:0] floor_q;
	logic [31:0] ceil_q;
	logic [31:0] start_value_q;
	logic [15:0] idle_limit_q;
	logic [31:0] edit_value;
	logic [3:0]  cursor_pos;
	logic [2:0]  prev_button;
	logic [15:0] idle_ticks;

	edit_result_t pending_results[$];
	plan_row_t    plan[$];
	int unsigned  src_idle_pct = 0;
	int unsigned  sink_idle_pct = 0;
	int unsigned  fault_count = 0;
	int unsigned  cycle_count = 0;

	button_digit_value_editor #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Digit count as the editor uses it.
	function automatic logic [4:0] shown_digits();
		if (digits_q < 5'd1)
			return 5'd1;
		if (digits_q > 5'(MAX_DIGITS))
			return 5'(MAX_DIGITS);
		return digits_q;
	endfunction

	// Value after stepping the digit under the cursor up or down, clamped.
	function automatic logic [31:0] stepped_value(input logic up);
		logic [63:0] base;
		logic [63:0] weight;
		logic [63:0] v;
		logic [63:0] digit;
		logic [63:0] nd;
		logic [63:0] rest;
		logic [4:0]  len;
		int unsigned pos;
		logic        fits;
		len = shown_digits();
		if (radix_q < 5'd2)
			base = 64'd2;
		else if (radix_q > 5'd16)
			base = 64'd16;
		else
			base = 64'(radix_q);
		// A cursor past the last digit works on the rightmost one.
		pos = (5'(cursor_pos) < len) ? int'(len) - 1 - int'(cursor_pos) : 0;
		weight = 64'd1;
		fits = 1'b1;
		v = 64'(edit_value);
		for (int i = 0; i < pos; i++) begin
			if (weight > VALUE_ONES / base) begin
				fits = 1'b0;
				break;
			end
			weight = weight * base;
		end
		// A digit whose weight overflows the value is left alone.
		if (fits) begin
			digit = (v / weight) % base;
			if (up)
				nd = (digit == base - 1) ? 64'd0 : digit + 1;
			else
				nd = (digit == 64'd0) ? base - 1 : digit - 1;
			rest = v - digit * weight;
			if (nd != 64'd0 && weight > (VALUE_ONES - rest) / nd)
				v = VALUE_ONES;
			else
				v = rest + nd * weight;
		end
		// With an inverted range, a value below the floor takes the floor, any other the ceiling.
		if (v < 64'(floor_q))
			v = 64'(floor_q);
		else if (v > 64'(ceil_q))
			v = 64'(ceil_q);
		return v[31:0];
	endfunction

	// Advance the session by one tick and return the result it gives.
	task automatic advance_editor(input logic [2:0] btn, input logic restart,
			output edit_result_t res);
		logic [1:0] status;
		logic [4:0] len;
		status = STAT_EDIT;
		len = shown_digits();
		if (restart) begin
			edit_value = start_value_q;
			cursor_pos = 4'(len - 5'd1);
			prev_button = btn;
			idle_ticks = '0;
		end else begin
			if (idle_ticks < IDLE_SAT)
				idle_ticks = idle_ticks + 16'd1;
			if (idle_ticks > idle_limit_q) begin
				status = STAT_TIMEOUT;
			end else if (btn != prev_button) begin
				prev_button = btn;
				idle_ticks = '0;
				case (btn)
					KEY_SELECT: status = STAT_SELECT;
					KEY_LEFT: begin
						cursor_pos = (cursor_pos == 4'd0) ? 4'(len - 5'd1) : cursor_pos - 4'd1;
					end
					KEY_RIGHT: begin
						cursor_pos = (5'(cursor_pos) >= len - 5'd1) ? 4'd0 : cursor_pos + 4'd1;
					end
					KEY_UP: edit_value = stepped_value(1'b1);
					KEY_DOWN: edit_value = stepped_value(1'b0);
					default: ;
				endcase
			end
		end
		res.value = edit_value;
		res.cursor = cursor_pos;
		res.status = status;
	endtask

	// Offer one input beat, wait for it to be taken and queue its result.
	task automatic send_tick(input logic [2:0] btn, input logic restart,
			input logic known = 1'b0, input edit_result_t want = '0);
		edit_result_t res;
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, restart, btn};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_editor(btn, restart, res);
		pending_results.push_back(known ? want : res);
	endtask

	// Stop sending and let every outstanding result drain.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write one register and mirror it into the model settings.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_RADIX:       radix_q = data[4:0];
			CFG_DIGIT_COUNT: digits_q = data[4:0];
			CFG_VALUE_MIN:   floor_q = data;
			CFG_VALUE_MAX:   ceil_q = data;
			CFG_INIT_VALUE:  start_value_q = data;
			CFG_TIMEOUT:     idle_limit_q = data[15:0];
			default: ;
		endcase
	endtask

	function automatic void plan_tick(input logic [2:0] btn, input logic restart);
		plan_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.button = btn;
		row.restart = restart;
		plan.push_back(row);
	endfunction

	function automatic void plan_known(input logic [2:0] btn, input logic restart,
			input logic [31:0] value, input logic [3:0] cursor, input logic [1:0] status);
		plan_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.button = btn;
		row.restart = restart;
		row.known = 1'b1;
		row.want.value = value;
		row.want.cursor = cursor;
		row.want.status = status;
		plan.push_back(row);
	endfunction

	function automatic void plan_write(input logic [2:0] idx, input logic [31:0] data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_data = data;
		plan.push_back(row);
	endfunction

	// One random session: new settings, then mostly press-and-release
	// sequences mixed with idle runs, noise and restarts.
	task automatic run_session(input int unsigned ticks);
		int unsigned sent;
		int unsigned pick;
		int unsigned hold;
		logic [2:0]  btn;
		logic [31:0] d;
		logic [31:0] lo;
		logic [31:0] hi;
		sent = 0;
		wait_quiet();
		d = $urandom;
		d[4:0] = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2, 16));
		write_reg(CFG_RADIX, d);
		d = $urandom;
		d[4:0] = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
		write_reg(CFG_DIGIT_COUNT, d);
		// Clamp range: full, random (possibly inverted) or ordered.
		case ($urandom_range(2))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = $urandom >> $urandom_range(31);
				hi = $urandom >> $urandom_range(31);
			end
			default: begin
				lo = $urandom >> $urandom_range(31);
				hi = $urandom >> $urandom_range(31);
				if (lo > hi) begin
					d = lo;
					lo = hi;
					hi = d;
				end
			end
		endcase
		write_reg(CFG_VALUE_MIN, lo);
		write_reg(CFG_VALUE_MAX, hi);
		write_reg(CFG_INIT_VALUE, $urandom >> $urandom_range(31));
		d = $urandom;
		case ($urandom_range(9))
			0: d[15:0] = '0;
			1, 2, 3: d[15:0] = 16'($urandom_range(1, 10));
			4, 5, 6: d[15:0] = 16'($urandom_range(11, 300));
			7: d[15:0] = '1;
			default: ;
		endcase
		write_reg(CFG_TIMEOUT, d);
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
		// Most sessions start clean; the rest keep a stale cursor.
		if ($urandom_range(99) < 80) begin
			send_tick(KEY_NONE, 1'b1);
			sent++;
		end
		while (sent < ticks) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				pick = $urandom_range(99);
				if (pick < 50)
					btn = $urandom_range(1) ? KEY_UP : KEY_DOWN;
				else if (pick < 85)
					btn = $urandom_range(1) ? KEY_LEFT : KEY_RIGHT;
				else
					btn = KEY_SELECT;
				hold = $urandom_range(1, 3);
				repeat (hold) send_tick(btn, 1'b0);
				sent += hold;
				repeat ($urandom_range(1, 3)) begin
					send_tick(KEY_NONE, 1'b0);
					sent++;
				end
			end else if (pick < 85) begin
				hold = $urandom_range(1, 15);
				repeat (hold) send_tick(KEY_NONE, 1'b0);
				sent += hold;
			end else if (pick < 95) begin
				send_tick(3'($urandom_range(7)), $urandom_range(9) == 0);
				sent++;
			end else begin
				send_tick(3'($urandom_range(7)), 1'b1);
				sent++;
			end
		end
	endtask

	// Result side: random back-pressure and the comparison.
	always @(posedge clk) begin
		edit_result_t want;
		edit_result_t got;
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[37:0];
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_SHOWN)
					$display("unexpected result beat: value %h cursor %0d status %0d",
						got.value, got.cursor, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.cursor !== want.cursor ||
						got.status !== want.status) begin
					fault_count++;
					if (fault_count <= MAX_SHOWN)
						$display("mismatch: value %h/%h cursor %0d/%0d status %0d/%0d (exp/got)",
							want.value, got.value, want.cursor, got.cursor,
							want.status, got.status);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		plan_row_t row;
		logic      settled;
		settled = 1'b0;
		radix_q = RST_RADIX;
		digits_q = RST_DIGIT_COUNT;
		floor_q = RST_VALUE_MIN;
		ceil_q = RST_VALUE_MAX;
		start_value_q = RST_INIT_VALUE;
		idle_limit_q = RST_TIMEOUT;
		edit_value = RST_INIT_VALUE;
		cursor_pos = 4'(shown_digits() - 5'd1);
		prev_button = KEY_NONE;
		idle_ticks = '0;

		// Defaults: wraps, overflow on the leftmost digit, spare codes, restart.
		plan_known(KEY_NONE, 1'b0, 32'd0, 4'd9, STAT_EDIT);
		plan_known(KEY_SELECT, 1'b0, 32'd0, 4'd9, STAT_SELECT);
		plan_known(KEY_RIGHT, 1'b0, 32'd0, 4'd0, STAT_EDIT);
		plan_known(KEY_DOWN, 1'b0, 32'hFFFF_FFFF, 4'd0, STAT_EDIT);
		plan_tick(KEY_UP, 1'b0);
		plan_tick(KEY_LEFT, 1'b0);
		plan_tick(KEY_SPARE_A, 1'b0);
		plan_tick(KEY_SPARE_B, 1'b0);
		plan_known(KEY_NONE, 1'b1, 32'd0, 4'd9, STAT_EDIT);
		// Radix and digit count below range, inverted clamp, short timeout.
		plan_write(CFG_RADIX, 32'd1);
		plan_write(CFG_DIGIT_COUNT, 32'd0);
		plan_write(CFG_VALUE_MIN, 32'd5);
		plan_write(CFG_VALUE_MAX, 32'd3);
		plan_write(CFG_TIMEOUT, 32'd2);
		plan_write(CFG_SPARE_A, 32'hFFFF_FFFF);
		plan_write(CFG_SPARE_B, 32'hFFFF_FFFF);
		plan_tick(KEY_UP, 1'b0);
		plan_tick(KEY_LEFT, 1'b0);
		plan_tick(KEY_RIGHT, 1'b0);
		repeat (4) plan_tick(KEY_NONE, 1'b0);
		plan_known(KEY_UP, 1'b1, 32'd0, 4'd0, STAT_EDIT);
		// Radix and digit count above range: the top digit weight overflows.
		plan_write(CFG_RADIX, 32'd31);
		plan_write(CFG_DIGIT_COUNT, 32'd31);
		plan_write(CFG_VALUE_MIN, 32'd0);
		plan_write(CFG_VALUE_MAX, 32'hFFFF_FFFF);
		plan_write(CFG_INIT_VALUE, 32'hFFFF_FFFF);
		plan_write(CFG_TIMEOUT, 32'hFFFF);
		plan_known(KEY_NONE, 1'b1, 32'hFFFF_FFFF, 4'd15, STAT_EDIT);
		plan_tick(KEY_RIGHT, 1'b0);
		plan_tick(KEY_UP, 1'b0);
		plan_tick(KEY_LEFT, 1'b0);
		plan_tick(KEY_DOWN, 1'b0);
		// Zero timeout: the very next tick times out.
		plan_write(CFG_TIMEOUT, 32'd0);
		plan_known(KEY_NONE, 1'b0, 32'hFFFF_FFFE, 4'd15, STAT_TIMEOUT);
		plan_write(CFG_RADIX, 32'(RST_RADIX));
		plan_write(CFG_DIGIT_COUNT, 32'(RST_DIGIT_COUNT));
		plan_write(CFG_TIMEOUT, 32'(RST_TIMEOUT));
		plan_tick(KEY_NONE, 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < plan.size(); k++) begin
			row = plan[k];
			if (row.kind == ROW_WRITE) begin
				if (!settled) begin
					wait_quiet();
					settled = 1'b1;
				end
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				send_tick(row.button, row.restart, row.known, row.want);
				settled = 1'b0;
			end
		end

		// Random sessions under three idling patterns.
		src_idle_pct = 30;
		sink_idle_pct <= 71;
		repeat (6) run_session(60);
		src_idle_pct = 71;
		sink_idle_pct <= 30;
		repeat (6) run_session(60);
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		repeat (6) run_session(60);

		wait_quiet();
		if (fault_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
